>>> sv/tepq_pkg.sv
// Package for the timed event priority queue: shared types, codes and constants.
// Used by tepq_ctrl, tepq_datapath and timed_event_priority_queue; depends on nothing.
package tepq_pkg;

  localparam int EventSlotsDef = 16;
  localparam int TimeBitsDef   = 32;
  localparam int IdW           = 4;
  localparam int FieldTimeW    = 32;

  // Operation codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_POP    = 3'd2,
    KIND_PEEK   = 3'd3,
    KIND_REBASE = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]            kind;
    logic [IdW-1:0]        event_id;
    logic [FieldTimeW-1:0] event_time;
    logic [FieldTimeW-1:0] time_offset;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]        head_id;
    logic [FieldTimeW-1:0] head_time;
    logic [1:0]            status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

>>> sv/tepq_ctrl.sv
// Controller state machine of the timed event priority queue.
// Depends on tepq_pkg.
module tepq_ctrl
  import tepq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands: capture a request, then execute it for one cycle.
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/tepq_datapath.sv
// Datapath of the timed event priority queue: an ordered chain of cells holding
// id and due time, per-slot queued flags and the fill count. Depends on tepq_pkg.
module tepq_datapath
  import tepq_pkg::*;
#(
  parameter int EVENT_SLOTS = EventSlotsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  localparam int N  = EVENT_SLOTS;
  localparam int CW = $clog2(EVENT_SLOTS + 1);

  req_t                 req_q;
  logic [IdW-1:0]       ids_q  [N];
  logic [IdW-1:0]       ids_d  [N];
  logic [TIME_BITS-1:0] tms_q  [N];
  logic [TIME_BITS-1:0] tms_d  [N];
  logic [N-1:0]         queued_q, queued_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 valid_q;
  rsp_t                 rsp_q, rsp_d;

  logic [TIME_BITS-1:0] t_in, off_in;
  logic [N-1:0]         le, hit, after, cell_valid;
  logic                 id_ok, is_queued, empty;

  assign t_in   = TIME_BITS'(req_q.event_time);
  assign off_in = TIME_BITS'(req_q.time_offset);
  assign empty  = (count_q == '0);
  assign id_ok  = (int'(req_q.event_id) < N);

  // Per-cell compares; every cell works on its own entry.
  always_comb begin
    is_queued = 1'b0;
    for (int p = 0; p < N; p++) begin
      cell_valid[p] = (CW'(p) < count_q);
      le[p]         = cell_valid[p] && (tms_q[p] <= t_in);
      hit[p]        = cell_valid[p] && (ids_q[p] == req_q.event_id);
      if (int'(req_q.event_id) == p) begin
        is_queued = queued_q[p];
      end
    end
    after[0] = hit[0];
    for (int p = 1; p < N; p++) begin
      after[p] = after[p-1] | hit[p];
    end
  end

  // Next state of the cell chain and the result of the executed operation.
  always_comb begin
    ids_d    = ids_q;
    tms_d    = tms_q;
    queued_d = queued_q;
    count_d  = count_q;
    rsp_d    = '0;
    rsp_d.status = ST_OK;
    case (req_q.kind)
      KIND_INSERT: begin
        if (!id_ok) begin
          rsp_d.status = ST_ABSENT;
        end else if (is_queued) begin
          rsp_d.status = ST_DUP;
        end else begin
          // Cells after the insertion point move up by one.
          for (int p = 0; p < N; p++) begin
            if (!le[p]) begin
              if (p == 0) begin
                ids_d[p] = req_q.event_id;
                tms_d[p] = t_in;
              end else if (le[(p > 0) ? p - 1 : 0]) begin
                ids_d[p] = req_q.event_id;
                tms_d[p] = t_in;
              end else begin
                ids_d[p] = ids_q[(p > 0) ? p - 1 : 0];
                tms_d[p] = tms_q[(p > 0) ? p - 1 : 0];
              end
            end
          end
          for (int s = 0; s < N; s++) begin
            if (int'(req_q.event_id) == s) begin
              queued_d[s] = 1'b1;
            end
          end
          count_d = count_q + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (!id_ok || !is_queued) begin
          rsp_d.status = ST_ABSENT;
        end else begin
          // Cells from the matching one onward take their upper neighbor.
          for (int p = 0; p < N - 1; p++) begin
            if (after[p]) begin
              ids_d[p] = ids_q[p+1];
              tms_d[p] = tms_q[p+1];
            end
          end
          for (int s = 0; s < N; s++) begin
            if (int'(req_q.event_id) == s) begin
              queued_d[s] = 1'b0;
            end
          end
          count_d = count_q - CW'(1);
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.head_id   = ids_q[0];
          rsp_d.head_time = FieldTimeW'(tms_q[0]);
          if (req_q.kind == KIND_POP) begin
            for (int p = 0; p < N - 1; p++) begin
              ids_d[p] = ids_q[p+1];
              tms_d[p] = tms_q[p+1];
            end
            for (int s = 0; s < N; s++) begin
              if (int'(ids_q[0]) == s) begin
                queued_d[s] = 1'b0;
              end
            end
            count_d = count_q - CW'(1);
          end
        end
      end
      KIND_REBASE: begin
        // Saturating subtract in every queued cell.
        for (int p = 0; p < N; p++) begin
          if (cell_valid[p]) begin
            tms_d[p] = (tms_q[p] > off_in) ? (tms_q[p] - off_in) : '0;
          end
        end
      end
      KIND_CLEAR: begin
        queued_d = '0;
        count_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state: queued flags, fill count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      count_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        queued_q <= queued_d;
        count_q  <= count_d;
      end
    end
  end

  // Payload: request capture, cell chain and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      ids_q <= ids_d;
      tms_q <= tms_d;
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

>>> sv/timed_event_priority_queue.sv
// Top level of the timed event priority queue.
// Depends on tepq_pkg, tepq_ctrl and tepq_datapath.
//
// Usage:
//   A request (kind, event_id, event_time, time_offset) is transferred at a
//   rising edge where start_i is high and busy_o is low. The block captures it,
//   executes it in the following cycle on a chain of ordered cells, and shows
//   exactly one result (head_id, head_time, status) on rsp_o for one cycle,
//   marked by valid_o, in the cycle after execution.
//   busy_o is high during the execute cycle, which is set by the single update
//   of the cell chain; no new request is taken until the last one is executed.
//   A new request may be transferred in the cycle the previous result shows.
//   Reset empties the queue and clears all queued flags at once; no sweep.
//   The receiver cannot stall: each result is taken in the cycle it is shown.
module timed_event_priority_queue
  import tepq_pkg::*;
#(
  parameter int EVENT_SLOTS = EventSlotsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  cmd_t cmd;

  tepq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  tepq_datapath #(
    .EVENT_SLOTS(EVENT_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

endmodule
